// File: hdl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Command and status codes for the indexed double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Command codes carried on in_cmd
  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_READ_INDEX = 3'd2;
  localparam cmd_t CMD_READ_FRONT = 3'd3;
  localparam cmd_t CMD_READ_BACK  = 3'd4;

  // Status codes carried on out_status
  typedef logic [1:0] status_t;
  localparam status_t ST_OK           = 2'd0;
  localparam status_t ST_OUT_OF_RANGE = 2'd1;
  localparam status_t ST_EMPTY        = 2'd2;
  localparam status_t ST_FULL         = 2'd3;

  // Fixed port widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned COUNT_W = 9;

endpackage

// File: hdl/double_ended_queue_indexed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_indexed
// Deque of DEPTH words in a ring buffer (head pointer plus count), with push
// at either end and read at the front, the back or any position.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  in_       in_valid / in_stall     in_cmd, in_value, in_index
//  out_      out_valid / out_stall   out_data, out_status, out_count, out_is_empty
//
//  One item is taken per cycle while in_stall is low; its result passes
//  through the word store read register, then the output register, to the out_ ports.
//  The single word store port serves one push write or one read per item;
//  head and count are updated at the edge that takes the item.
//  Reset clears head, count and the valid flags; the word store is not cleared.
//  in_stall rises only when both result stages hold items and out_stall is high.
// ----------------------------------------------------------------------------
module double_ended_queue_indexed
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command items
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_cmd,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [INDEX_W-1:0]        in_index,
  // result items
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_data,
  output logic [1:0]                out_status,
  output logic [COUNT_W-1:0]        out_count,
  output logic                      out_is_empty
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  typedef logic [AW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;

  // Word store
  logic [WORD_WIDTH-1:0] mem [DEPTH];

  // Control state
  ptr_t    head_r, head_nxt;
  cnt_t    count_r, count_nxt;

  // Read stage
  logic                  s1_valid_r;
  status_t               s1_status_r;
  cnt_t                  s1_count_r;
  logic                  s1_rd_r;
  logic [WORD_WIDTH-1:0] rd_data_r;

  // Output stage
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_data_r;
  status_t                   out_status_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic                      out_is_empty_r;

  // Handshake
  logic accept, s1_adv;

  assign s1_adv   = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_adv;
  assign accept   = in_valid & ~in_stall;

  // Command decode and address generation
  logic                  full, empty, idx_ok;
  logic [CMPW-1:0]       idx_c, cnt_c;
  ptr_t                  pos, slot, head_dec;
  logic [AW:0]           sum;
  status_t               status;
  logic                  mem_we, mem_re;
  ptr_t                  mem_addr;
  logic [WORD_WIDTH+VALUE_W-1:0] val_ext;
  logic [WORD_WIDTH-1:0] wdata;

  assign full     = (count_r == cnt_t'(DEPTH));
  assign empty    = (count_r == '0);
  assign idx_c    = CMPW'(in_index);
  assign cnt_c    = CMPW'(count_r);
  assign idx_ok   = (idx_c < cnt_c);
  assign head_dec = (head_r == '0) ? ptr_t'(DEPTH - 1) : head_r - ptr_t'(1);
  assign val_ext  = (WORD_WIDTH + VALUE_W)'($unsigned(in_value));
  assign wdata    = val_ext[WORD_WIDTH-1:0];

  // Physical slot of a position: head + pos, wrapped once
  assign sum  = {1'b0, head_r} + {1'b0, pos};
  assign slot = (sum >= (AW + 1)'(DEPTH)) ? ptr_t'(sum - (AW + 1)'(DEPTH)) : ptr_t'(sum);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    status    = ST_OK;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    pos       = '0;
    mem_addr  = slot;
    unique case (in_cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          head_nxt  = head_dec;
          count_nxt = count_r + cnt_t'(1);
          mem_we    = 1'b1;
          mem_addr  = head_dec;
        end
      end
      CMD_PUSH_BACK: begin
        pos = ptr_t'(count_r);
        if (full) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + cnt_t'(1);
          mem_we    = 1'b1;
        end
      end
      CMD_READ_INDEX: begin
        pos = ptr_t'(idx_c);
        if (idx_ok) mem_re = 1'b1;
        else        status = ST_OUT_OF_RANGE;
      end
      CMD_READ_FRONT: begin
        if (empty) status = ST_EMPTY;
        else       mem_re = 1'b1;
      end
      CMD_READ_BACK: begin
        pos = ptr_t'(count_r - cnt_t'(1));
        if (empty) status = ST_EMPTY;
        else       mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Word store port: one write or one registered read per item
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      mem[mem_addr] <= wdata;
    end
    if (accept && mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // Head and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Read stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept | (s1_valid_r & ~s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
      s1_count_r  <= count_nxt;
      s1_rd_r     <= mem_re;
    end
  end

  // Sign-extend the stored word and fold the count to the port width
  logic signed [WORD_WIDTH-1:0]         rd_s;
  logic signed [WORD_WIDTH+VALUE_W-1:0] rd_x;
  logic [CW+COUNT_W-1:0]                cnt_x;

  assign rd_s  = rd_data_r;
  assign rd_x  = (WORD_WIDTH + VALUE_W)'(rd_s);
  assign cnt_x = (CW + COUNT_W)'(s1_count_r);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_adv | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r     <= s1_rd_r ? rd_x[VALUE_W-1:0] : '0;
      out_status_r   <= s1_status_r;
      out_count_r    <= cnt_x[COUNT_W-1:0];
      out_is_empty_r <= (s1_count_r == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_is_empty_r;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed double-ended queue. A directed opening
// covers empty reads, unused codes and extreme words; random commands then
// fill the ring to full and keep reading and pushing against it. Each
// accepted command updates a local deque model whose result is compared
// field by field with the result item, under rotating idle and stall phases.
// ----------------------------------------------------------------------------
module tb_top;
  import deq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_LEN = 120;

  typedef struct {
    cmd_t                      cmd;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
  } deq_cmd_t;

  typedef struct {
    logic signed [VALUE_W-1:0] data;
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
  } deq_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [2:0]                in_cmd = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic [INDEX_W-1:0]        in_index = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] out_data;
  logic [1:0]                out_status;
  logic [COUNT_W-1:0]        out_count;
  logic                      out_is_empty;

  double_ended_queue_indexed dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_is_empty (out_is_empty)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  deq_cmd_t    pending_cmds[$];
  deq_result_t expected_results[$];
  int          total_cmds = 0;
  int          cmds_accepted = 0;
  int          results_checked = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  // deque model state
  logic [VALUE_W-1:0] model_words[QUEUE_DEPTH];
  logic [INDEX_W-1:0] model_head = '0;
  logic [COUNT_W-1:0] model_count = '0;
  int                 status_seen[4] = '{0, 0, 0, 0};
  int                 peak_count = 0;

  // idle percentages for sender and receiver, rotating every PHASE_LEN items
  function automatic int sender_idle_pct(int n);
    case ((n / PHASE_LEN) % 4)
      1: return 55;
      3: return 17;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(int n);
    case ((n / PHASE_LEN) % 4)
      2: return 55;
      3: return 17;
      default: return 0;
    endcase
  endfunction

  // apply one command to the model and return the result it produces
  function automatic deq_result_t deque_apply(deq_cmd_t c);
    deq_result_t        r;
    logic [INDEX_W-1:0] slot;
    r.data = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_PUSH_FRONT: begin
        if (model_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          model_head = model_head - 1'b1;
          model_words[model_head] = c.value;
          model_count = model_count + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (model_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = model_head + model_count[INDEX_W-1:0];
          model_words[slot] = c.value;
          model_count = model_count + 1'b1;
        end
      end
      CMD_READ_INDEX: begin
        if (COUNT_W'(c.index) >= model_count) begin
          r.status = ST_OUT_OF_RANGE;
        end else begin
          slot = model_head + c.index;
          r.data = model_words[slot];
        end
      end
      CMD_READ_FRONT: begin
        if (model_count == 0) r.status = ST_EMPTY;
        else r.data = model_words[model_head];
      end
      CMD_READ_BACK: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = model_head + model_count[INDEX_W-1:0] - 1'b1;
          r.data = model_words[slot];
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
    r.count = model_count;
    r.is_empty = (model_count == 0);
    status_seen[r.status]++;
    if (model_count > peak_count) peak_count = int'(model_count);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH item %0d: %s", $time, results_checked, what);
    error_count++;
  endtask

  // driver: present queued items, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(),
                                deque_apply('{in_cmd, in_value, in_index}));
        cmds_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 &&
            $urandom_range(99) >= sender_idle_pct(cmds_accepted)) begin
          in_valid <= 1'b1;
          in_cmd   <= pending_cmds[0].cmd;
          in_value <= pending_cmds[0].value;
          in_index <= pending_cmds[0].index;
          void'(pending_cmds.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compare each accepted result item
  always @(posedge clk) begin
    deq_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want.data)
            report_mismatch($sformatf("data %h, expected %h", out_data, want.data));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", out_count, want.count));
          if (out_is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %b, expected %b",
                                      out_is_empty, want.is_empty));
        end
        results_checked++;
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct(cmds_accepted));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d items still expected",
               cycle_count, expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // occupancy as seen by the generator, for biasing indexes near the edge
  int gen_count = 0;

  task automatic queue_cmd(cmd_t c, logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] i);
    pending_cmds.insert(pending_cmds.size(), deq_cmd_t'{c, v, i});
    total_cmds++;
    if ((c == CMD_PUSH_FRONT || c == CMD_PUSH_BACK) && gen_count < QUEUE_DEPTH)
      gen_count++;
  endtask

  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int                 pick;
    logic [INDEX_W-1:0] idx;

    // directed opening: empty store, unused codes, extreme words
    queue_cmd(CMD_READ_FRONT, '0, '0);
    queue_cmd(CMD_READ_BACK, '1, '1);
    queue_cmd(CMD_READ_INDEX, '0, 8'd0);
    queue_cmd(CMD_READ_INDEX, '0, 8'd255);
    queue_cmd(cmd_t'(3'd5), 32'h1234_5678, 8'd1);
    queue_cmd(cmd_t'(3'd6), '1, 8'd0);
    queue_cmd(cmd_t'(3'd7), '0, '1);
    queue_cmd(CMD_PUSH_BACK, 32'h7FFF_FFFF, 8'd0);
    queue_cmd(CMD_PUSH_FRONT, 32'h8000_0000, '1);
    queue_cmd(CMD_PUSH_BACK, 32'h0000_0000, 8'd0);
    queue_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 8'd0);
    queue_cmd(CMD_PUSH_BACK, 32'hAAAA_AAAA, 8'd0);
    queue_cmd(CMD_PUSH_FRONT, 32'h5555_5555, 8'd0);
    queue_cmd(CMD_READ_FRONT, '0, '0);
    queue_cmd(CMD_READ_BACK, '0, '0);
    for (int k = 0; k <= 6; k++) queue_cmd(CMD_READ_INDEX, '0, INDEX_W'(k));
    queue_cmd(CMD_READ_INDEX, '0, 8'd170);
    queue_cmd(CMD_READ_INDEX, '0, 8'd255);

    // random mix: the store fills part way through, then refused pushes
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      idx = INDEX_W'($urandom);
      if ($urandom_range(3) == 0 && gen_count > 0)
        idx = INDEX_W'(gen_count - 1 + $urandom_range(1));
      if (pick < 15)      queue_cmd(CMD_PUSH_FRONT, random_word(), INDEX_W'($urandom));
      else if (pick < 30) queue_cmd(CMD_PUSH_BACK, random_word(), INDEX_W'($urandom));
      else if (pick < 62) queue_cmd(CMD_READ_INDEX, $urandom, idx);
      else if (pick < 75) queue_cmd(CMD_READ_FRONT, $urandom, INDEX_W'($urandom));
      else if (pick < 88) queue_cmd(CMD_READ_BACK, $urandom, INDEX_W'($urandom));
      else if (pick < 91) queue_cmd(cmd_t'($urandom_range(7, 5)), $urandom,
                                    INDEX_W'($urandom));
      else                queue_cmd(CMD_READ_INDEX, $urandom, INDEX_W'($urandom_range(3)));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (cmds_accepted < total_cmds) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results over %0d commands; peak occupancy %0d of %0d",
             results_checked, total_cmds, peak_count, QUEUE_DEPTH);
    $display("Status mix: ok %0d, out of range %0d, empty %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_OUT_OF_RANGE],
             status_seen[ST_EMPTY], status_seen[ST_FULL]);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/deq_pkg.sv
hdl/double_ended_queue_indexed.sv
verif/tb_top.sv
